// ===== hdl/blmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blmp_pkg
// Shared types and constants of the box to label map painter.
// ----------------------------------------------------------------------------
package blmp_pkg;

  // default geometry
  localparam int unsigned MAX_ROWS_DEF   = 64;
  localparam int unsigned MAX_COLS_DEF   = 64;
  localparam int unsigned COORD_FRAC_DEF = 16;

  // fixed field widths
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned COORD_W    = 17;
  localparam int unsigned LABEL_W    = 8;
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned CELL_W     = 6;
  localparam int unsigned AREA_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned QUEUE_DEPTH = 4;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PAINT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF   = 2'd3;

  // register reset values
  localparam logic [SIZE_W-1:0]  HEIGHT_RST = 7'd64;
  localparam logic [SIZE_W-1:0]  WIDTH_RST  = 7'd64;
  localparam logic [LABEL_W-1:0] BG_RST     = 8'd0;
  localparam logic               DIFF_RST   = 1'b1;

  localparam logic [AREA_W-1:0] AREA_CAP = 32'hFFFF_FFFE;
  localparam logic [AREA_W-1:0] AREA_INF = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_PAINT,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    logic [SIZE_W-1:0]  height;
    logic [SIZE_W-1:0]  width;
    logic [LABEL_W-1:0] bg;
    logic               use_diff;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [LABEL_W-1:0] label;
    logic [AREA_W-1:0]  area;
    logic [SIZE_W-1:0]  r0;
    logic [SIZE_W-1:0]  r1;
    logic [SIZE_W-1:0]  c0;
    logic [SIZE_W-1:0]  c1;
    logic               rd_hit;
    logic [CELL_W-1:0]  rd_row;
    logic [CELL_W-1:0]  rd_col;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/blmp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blmp_fifo
// Short command queue between the classifier and the map sequencer.
// ----------------------------------------------------------------------------
module blmp_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire blmp_pkg::cmd_t  push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output blmp_pkg::cmd_t       pop_data_o,
  output logic                 valid_o
);
  import blmp_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  cmd_t           mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [PW:0]    cnt_q;

  assign full_o     = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (pop_i)  rd_q <= rd_q + PW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (PW+1)'(1);
      else if (!push_i && pop_i) cnt_q <= cnt_q - (PW+1)'(1);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/blmp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blmp_front
// Accepts items, filters boxes, computes cell ranges and box area.
// ----------------------------------------------------------------------------
module blmp_front #(
  parameter int unsigned MAX_ROWS        = blmp_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS        = blmp_pkg::MAX_COLS_DEF,
  parameter int unsigned COORD_FRAC_BITS = blmp_pkg::COORD_FRAC_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire blmp_pkg::cfg_t                cfg_i,
  input  wire logic                          init_done_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [blmp_pkg::ACT_W-1:0]    action_i,
  input  wire logic [blmp_pkg::COORD_W-1:0]  box_left_i,
  input  wire logic [blmp_pkg::COORD_W-1:0]  box_top_i,
  input  wire logic [blmp_pkg::COORD_W-1:0]  box_right_i,
  input  wire logic [blmp_pkg::COORD_W-1:0]  box_bottom_i,
  input  wire logic [blmp_pkg::LABEL_W-1:0]  box_label_i,
  input  wire logic                          box_difficult_i,
  input  wire logic [blmp_pkg::CELL_W-1:0]   cell_row_i,
  input  wire logic [blmp_pkg::CELL_W-1:0]   cell_col_i,
  output logic                               push_o,
  output blmp_pkg::cmd_t                     cmd_o,
  input  wire logic                          full_i
);
  import blmp_pkg::*;

  localparam int unsigned F    = COORD_FRAC_BITS;
  localparam int unsigned CWID = (F + 1 > COORD_W) ? F + 1 : COORD_W;
  localparam int unsigned SHL  = (2 * F >= AREA_W) ? 0 : AREA_W - 2 * F;
  localparam int unsigned SHR  = (2 * F >= AREA_W) ? 2 * F - AREA_W : 0;
  localparam int unsigned PW   = 2 * CWID + AREA_W;
  localparam logic [CWID-1:0] ONE = {{(CWID-1){1'b0}}, 1'b1} << F;

  function automatic logic [CWID-1:0] sat(input logic [COORD_W-1:0] c);
    logic [CWID-1:0] x;
    x = CWID'(c);
    return (x > ONE) ? ONE : x;
  endfunction

  function automatic logic [SIZE_W-1:0] idx(input logic [SIZE_W-1:0] size,
                                             input logic [CWID-1:0] coord);
    logic [SIZE_W+CWID-1:0] p;
    p = {{CWID{1'b0}}, size} * {{SIZE_W{1'b0}}, coord};
    return p[F +: SIZE_W];
  endfunction

  // input stage
  logic                st_valid_q;
  logic [ACT_W-1:0]    act_q;
  logic [COORD_W-1:0]  l_q, t_q, r_q, b_q;
  logic [LABEL_W-1:0]  lab_q;
  logic                diff_q;
  logic [CELL_W-1:0]   row_q, col_q;

  logic                need_push, st_done;
  logic [SIZE_W-1:0]   h, w, r0, r1, c0, c1, r1e, c1e;
  logic [CWID-1:0]     ls, ts, rs, bs;
  logic [2*CWID-1:0]   prod;
  logic [PW-1:0]       full_area;
  logic [AREA_W-1:0]   area;
  logic                skip;

  assign st_done    = !need_push || !full_i;
  assign in_ready_o = init_done_i && (!st_valid_q || st_done);
  assign push_o     = st_valid_q && need_push && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      st_valid_q <= in_valid_i;
    end else if (st_done) begin
      st_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= action_i;
      l_q    <= box_left_i;
      t_q    <= box_top_i;
      r_q    <= box_right_i;
      b_q    <= box_bottom_i;
      lab_q  <= box_label_i;
      diff_q <= box_difficult_i;
      row_q  <= cell_row_i;
      col_q  <= cell_col_i;
    end
  end

  // effective map size
  assign h = (SIZE_W'(MAX_ROWS) < cfg_i.height && MAX_ROWS < (1 << SIZE_W))
             ? SIZE_W'(MAX_ROWS) : cfg_i.height;
  assign w = (SIZE_W'(MAX_COLS) < cfg_i.width && MAX_COLS < (1 << SIZE_W))
             ? SIZE_W'(MAX_COLS) : cfg_i.width;

  // cell ranges and area
  always_comb begin
    ls   = sat(l_q);
    ts   = sat(t_q);
    rs   = sat(r_q);
    bs   = sat(b_q);
    r0   = idx(h, ts);
    r1   = idx(h, bs);
    c0   = idx(w, ls);
    c1   = idx(w, rs);
    r1e  = (r1 < h) ? r1 : h;
    c1e  = (c1 < w) ? c1 : w;
    prod = {{CWID{1'b0}}, rs - ls} * {{CWID{1'b0}}, bs - ts};
    full_area = ({{AREA_W{1'b0}}, prod} << SHL) >> SHR;
    area = (full_area > PW'(AREA_CAP)) ? AREA_CAP : full_area[AREA_W-1:0];
    skip = (lab_q == cfg_i.bg) || (diff_q && !cfg_i.use_diff) ||
           (rs <= ls) || (bs <= ts) || (r0 >= r1e) || (c0 >= c1e);
  end

  // classify
  always_comb begin
    cmd_o        = '0;
    cmd_o.label  = lab_q;
    cmd_o.area   = area;
    cmd_o.r0     = r0;
    cmd_o.r1     = r1e;
    cmd_o.c0     = c0;
    cmd_o.c1     = c1e;
    cmd_o.rd_row = row_q;
    cmd_o.rd_col = col_q;
    cmd_o.rd_hit = ({1'b0, row_q} < h) && ({1'b0, col_q} < w);
    need_push    = 1'b0;
    unique case (act_q)
      ACT_CLEAR: begin
        cmd_o.kind = CMD_CLEAR;
        need_push  = 1'b1;
      end
      ACT_PAINT: begin
        cmd_o.kind = CMD_PAINT;
        need_push  = !skip;
      end
      ACT_READ: begin
        cmd_o.kind = CMD_READ;
        need_push  = 1'b1;
      end
      default: begin
        cmd_o.kind = CMD_CLEAR;
        need_push  = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/blmp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blmp_back
// Map sequencer: clears, paints cell by cell and reads the label memory.
// ----------------------------------------------------------------------------
module blmp_back #(
  parameter int unsigned MAX_ROWS = blmp_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = blmp_pkg::MAX_COLS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire blmp_pkg::cmd_t                cmd_i,
  output logic                               pop_o,
  output logic                               init_done_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [blmp_pkg::LABEL_W-1:0]       cell_label_o
);
  import blmp_pkg::*;

  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned EW    = LABEL_W + AREA_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PAINT = 2'd2;
  localparam logic [1:0] S_RDATA = 2'd3;

  logic [EW-1:0]       mem [DEPTH];
  logic [EW-1:0]       rdata_q;
  logic [1:0]          state_q, state_d;
  logic [AW-1:0]       cnt_q, paddr_q, raddr, waddr;
  logic [SIZE_W-1:0]   y_q, x_q, r1_q, c0_q, c1_q;
  logic [LABEL_W-1:0]  lab_q;
  logic [AREA_W-1:0]   area_q;
  logic                pend_q, init_q, we;
  logic [EW-1:0]       wdata;
  logic [AW-1:0]       cell_yx, rd_addr;

  assign init_done_o  = init_q;
  assign cell_yx      = {RW'(y_q), CW'(x_q)};
  assign rd_addr      = {RW'(cmd_i.rd_row), CW'(cmd_i.rd_col)};
  assign pop_o        = (state_q == S_IDLE) && valid_i && !pend_q &&
                        ((cmd_i.kind != CMD_READ) || !out_valid_o);

  // memory ports
  always_comb begin
    raddr = (state_q == S_PAINT) ? cell_yx : rd_addr;
    we    = 1'b0;
    waddr = paddr_q;
    wdata = {lab_q, area_q};
    if (state_q == S_CLEAR) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = {{LABEL_W{1'b0}}, AREA_INF};
    end else if (pend_q && (rdata_q[AREA_W-1:0] > area_q)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (cnt_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (pop_o) begin
          unique case (cmd_i.kind)
            CMD_CLEAR: state_d = S_CLEAR;
            CMD_PAINT: state_d = S_PAINT;
            CMD_READ:  state_d = cmd_i.rd_hit ? S_RDATA : S_IDLE;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_PAINT: begin
        if ((x_q + SIZE_W'(1) == c1_q) && (y_q + SIZE_W'(1) == r1_q)) state_d = S_IDLE;
      end
      S_RDATA: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      init_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == S_PAINT);
      if (state_q == S_CLEAR) begin
        cnt_q <= cnt_q + AW'(1);
        if (cnt_q == '1) init_q <= 1'b1;
      end
      if (pop_o && cmd_i.kind == CMD_CLEAR) cnt_q <= '0;
      // result beat
      if ((state_q == S_RDATA) ||
          (pop_o && cmd_i.kind == CMD_READ && !cmd_i.rd_hit)) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // paint walk and result payload
  always_ff @(posedge clk_i) begin
    paddr_q <= cell_yx;
    if (pop_o && cmd_i.kind == CMD_PAINT) begin
      y_q    <= cmd_i.r0;
      x_q    <= cmd_i.c0;
      r1_q   <= cmd_i.r1;
      c0_q   <= cmd_i.c0;
      c1_q   <= cmd_i.c1;
      lab_q  <= cmd_i.label;
      area_q <= cmd_i.area;
    end else if (state_q == S_PAINT) begin
      if (x_q + SIZE_W'(1) == c1_q) begin
        x_q <= c0_q;
        y_q <= y_q + SIZE_W'(1);
      end else begin
        x_q <= x_q + SIZE_W'(1);
      end
    end
    if (state_q == S_RDATA) begin
      cell_label_o <= rdata_q[EW-1:AREA_W];
    end else if (pop_o && cmd_i.kind == CMD_READ && !cmd_i.rd_hit) begin
      cell_label_o <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/box_to_label_map_painter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_to_label_map_painter
// Paints normalized boxes into a label map, smallest box wins per cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item per beat:
//   clear, paint box or read cell. Only a read returns a beat on the
//   output channel (out_valid_o / out_ready_i) holding cell_label_o.
//   Config channel (cfg_valid_i / cfg_ready_o) writes map_height,
//   map_width, background_label and use_difficult; write only when idle.
//   A front stage classifies items into a 4-entry queue; the back
//   sequencer then clears every memory entry in turn on a clear,
//   paints each covered cell in turn on a paint and reads one cell on
//   a read; a read outside the map answers zero without a memory read.
//   The label/area memory takes one read and one write a cycle.
//   After reset every memory entry is swept (MAX_ROWS*MAX_COLS, 4096 by
//   default, rounded up to powers of two per side) with in_ready_o low.
//   A stalled receiver holds the result; reads behind it wait in the
//   queue while the front keeps taking items until the queue fills.
// ----------------------------------------------------------------------------
module box_to_label_map_painter #(
  parameter int unsigned MAX_ROWS        = blmp_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS        = blmp_pkg::MAX_COLS_DEF,
  parameter int unsigned COORD_FRAC_BITS = blmp_pkg::COORD_FRAC_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [blmp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [blmp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [blmp_pkg::ACT_W-1:0]       action_i,
  input  wire logic [blmp_pkg::COORD_W-1:0]     box_left_i,
  input  wire logic [blmp_pkg::COORD_W-1:0]     box_top_i,
  input  wire logic [blmp_pkg::COORD_W-1:0]     box_right_i,
  input  wire logic [blmp_pkg::COORD_W-1:0]     box_bottom_i,
  input  wire logic [blmp_pkg::LABEL_W-1:0]     box_label_i,
  input  wire logic                             box_difficult_i,
  input  wire logic [blmp_pkg::CELL_W-1:0]      cell_row_i,
  input  wire logic [blmp_pkg::CELL_W-1:0]      cell_col_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [blmp_pkg::LABEL_W-1:0]          cell_label_o
);
  import blmp_pkg::*;

  cfg_t  cfg_q;
  cmd_t  push_cmd, pop_cmd;
  logic  push, full, pop, q_valid, init_done;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.height   <= HEIGHT_RST;
      cfg_q.width    <= WIDTH_RST;
      cfg_q.bg       <= BG_RST;
      cfg_q.use_diff <= DIFF_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEIGHT: cfg_q.height   <= cfg_data_i[SIZE_W-1:0];
        CFG_WIDTH:  cfg_q.width    <= cfg_data_i[SIZE_W-1:0];
        CFG_BG:     cfg_q.bg       <= cfg_data_i[LABEL_W-1:0];
        CFG_DIFF:   cfg_q.use_diff <= cfg_data_i[0];
        default:    cfg_q          <= cfg_q;
      endcase
    end
  end

  blmp_front #(
    .MAX_ROWS        (MAX_ROWS),
    .MAX_COLS        (MAX_COLS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .init_done_i     (init_done),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .box_left_i      (box_left_i),
    .box_top_i       (box_top_i),
    .box_right_i     (box_right_i),
    .box_bottom_i    (box_bottom_i),
    .box_label_i     (box_label_i),
    .box_difficult_i (box_difficult_i),
    .cell_row_i      (cell_row_i),
    .cell_col_i      (cell_col_i),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .full_i          (full)
  );

  blmp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .valid_o     (q_valid)
  );

  blmp_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .init_done_o  (init_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_label_o (cell_label_o)
  );

endmodule
`default_nettype wire

// ===== hdl/blmp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blmp_checker
// Port-level checks of the painter, bound to the top level.
// ----------------------------------------------------------------------------
module blmp_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           cfg_ready_o,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [blmp_pkg::LABEL_W-1:0]   cell_label_o
);
  import blmp_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_label_o))
    else $error("result beat dropped or changed under stall");

  // memory sweep blocks input right after reset
  a_init_block: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input taken during reset sweep");

  // no result can exist right after reset
  a_no_early_out: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat right after reset");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port stalled");

endmodule

bind box_to_label_map_painter blmp_checker u_blmp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_ready_o  (cfg_ready_o),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .cell_label_o (cell_label_o)
);
`default_nettype wire
